FILE: rtl/core/ctrb_pkg.sv
`default_nettype none

package ctrb_pkg;

  // ring size: the ring holds at most DEPTH - 1 bytes
  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);

  // fixed widths of the index, length and free-space fields
  localparam int FIELD_W = 10;
  localparam int BYTE_W  = 8;
  localparam int WIDE_W  = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_DONE = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_of_message;
    logic [FIELD_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic                accepted;
    logic                start_valid;
    logic [FIELD_W-1:0]  start_index;
    logic [FIELD_W-1:0]  start_length;
    logic [BYTE_W-1:0]   read_data;
    logic [FIELD_W-1:0]  space_left;
    logic                busy_res;
  } result_t;

  // pointer-width value onto a fixed-width result field
  function automatic logic [FIELD_W-1:0] to_field(input logic [PTR_W-1:0] v);
    logic [WIDE_W-1:0] w;
    begin
      w = WIDE_W'(v);
      return w[FIELD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ctrb_ram.sv
`default_nettype none

module ctrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/chunked_tx_ring_buffer.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------
// request   | start high, busy low  | item   (ctrb_pkg::item_t)
// result    | done high, one cycle  | result (ctrb_pkg::result_t)
//
// one request per cycle outside reset; its result strobe passes the request
// register and then the result register (store read lines up).
// rst is synchronous; busy is high while rst is high. pointers and flags
// clear at once, the byte store is not cleared.
// the receiver cannot stall, so busy never rises outside reset.
`default_nettype none

module chunked_tx_ring_buffer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ctrb_pkg::item_t   item,
  output logic                   done,
  output ctrb_pkg::result_t      result
);

  localparam int PW = ctrb_pkg::PTR_W;

  // request register
  logic              v1;
  ctrb_pkg::item_t   item_q;

  // ring state
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] inflight;
  logic          busy_flag;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic [PW-1:0] inflight_next;
  logic          busy_flag_next;

  // result register
  ctrb_pkg::result_t res_q;
  ctrb_pkg::result_t res_next;
  logic              rd_q;
  logic              rd_next;

  // store port
  logic                          ram_we;
  logic [PW-1:0]                 ram_raddr;
  logic [ctrb_pkg::BYTE_W-1:0]   ram_q;

  logic [PW-1:0] head_inc;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] chunk_len;
  logic [PW:0]   used;
  logic [PW:0]   free_w;
  logic          check;
  logic          launch;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    if (start && !busy) begin
      item_q <= item;
    end
  end

  always_comb begin
    head_inc  = (head == PW'(ctrb_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
    tail_sum  = {1'b0, tail} + {1'b0, inflight};
    ram_raddr = item_q.read_index[PW-1:0];

    head_next      = head;
    tail_next      = tail;
    inflight_next  = inflight;
    busy_flag_next = busy_flag;
    ram_we         = 1'b0;
    check          = 1'b0;
    rd_next        = 1'b0;

    res_next = '0;

    if (v1) begin
      case (item_q.mode)
        ctrb_pkg::MODE_PUSH: begin
          if (head_inc != tail) begin
            ram_we            = 1'b1;
            head_next         = head_inc;
            res_next.accepted = 1'b1;
          end
          check = item_q.last_of_message;
        end
        ctrb_pkg::MODE_DONE: begin
          // chunk never runs past the array end, so one wrap check suffices
          tail_next      = (tail_sum == (PW + 1)'(ctrb_pkg::DEPTH)) ? '0
                                                                     : tail_sum[PW-1:0];
          inflight_next  = '0;
          busy_flag_next = 1'b0;
          check          = 1'b1;
        end
        ctrb_pkg::MODE_READ: begin
          rd_next = (32'(item_q.read_index) < ctrb_pkg::DEPTH);
        end
        default: begin
        end
      endcase
    end

    // chunk runs to head, or to the array end when the data wraps
    chunk_len = (head_next > tail_next) ? head_next - tail_next
                                        : PW'(ctrb_pkg::DEPTH - 32'(tail_next));
    launch = check && !busy_flag_next && (head_next != tail_next);
    if (launch) begin
      busy_flag_next        = 1'b1;
      inflight_next         = chunk_len;
      res_next.start_valid  = 1'b1;
      res_next.start_index  = ctrb_pkg::to_field(tail_next);
      res_next.start_length = ctrb_pkg::to_field(chunk_len);
    end

    used = (head_next >= tail_next) ? {1'b0, head_next} - {1'b0, tail_next}
                                    : (PW + 1)'(ctrb_pkg::DEPTH)
                                      - ({1'b0, tail_next} - {1'b0, head_next});
    free_w = (PW + 1)'(ctrb_pkg::DEPTH - 1) - used;
    res_next.space_left = ctrb_pkg::to_field(free_w[PW-1:0]);
    res_next.busy_res   = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      inflight  <= '0;
      busy_flag <= 1'b0;
      done      <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      inflight  <= inflight_next;
      busy_flag <= busy_flag_next;
      done      <= v1;
    end
    res_q <= res_next;
    rd_q  <= rd_next;
  end

  ctrb_ram #(
    .WIDTH (ctrb_pkg::BYTE_W),
    .DEPTH (ctrb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head),
    .wdata (item_q.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // read byte joins the registered fields as it leaves the store
  always_comb begin
    result           = res_q;
    result.read_data = rd_q ? ram_q : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ctrb_checker.sv
`default_nettype none

module ctrb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire ctrb_pkg::result_t result
);

  // every accepted request yields its result through the request and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request without result");

  // no result without a matching accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without request");

  // a started chunk leaves a transfer in flight and is never empty
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (done && result.start_valid) |-> (result.busy_res && result.start_length != '0))
    else $error("chunk start inconsistent");

  // without a start the chunk fields stay clear
  a_no_start: assert property (@(posedge clk) disable iff (rst)
    (done && !result.start_valid) |-> (result.start_index == '0 && result.start_length == '0))
    else $error("chunk fields set without start");

endmodule

bind chunked_tx_ring_buffer ctrb_checker u_ctrb_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
module testbench;

  localparam int DEPTH   = ctrb_pkg::DEPTH;
  localparam int BYTE_W  = ctrb_pkg::BYTE_W;
  localparam int FIELD_W = ctrb_pkg::FIELD_W;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  ctrb_pkg::item_t item = '0;
  logic busy;
  logic done;
  ctrb_pkg::result_t result;

  chunked_tx_ring_buffer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  // predicted ring state
  logic [BYTE_W-1:0] ring_bytes [DEPTH];
  bit ring_written [DEPTH];
  int ring_written_count = 0;
  int ring_head = 0;
  int ring_tail = 0;
  int ring_inflight = 0;
  bit ring_busy = 1'b0;

  ctrb_pkg::result_t pending_results [$];
  ctrb_pkg::result_t expected_now;
  int error_count = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int ring_free();
    int used;
    if (ring_head >= ring_tail) used = ring_head - ring_tail;
    else used = DEPTH - (ring_tail - ring_head);
    return DEPTH - 1 - used;
  endfunction

  function automatic ctrb_pkg::result_t predict_ring_result(input ctrb_pkg::item_t it);
    ctrb_pkg::result_t r;
    logic check;
    int nxt;
    int len;
    r = '0;
    check = 1'b0;
    case (it.mode)
      ctrb_pkg::MODE_PUSH: begin
        nxt = (ring_head + 1) % DEPTH;
        if (nxt != ring_tail) begin
          ring_bytes[ring_head] = it.data_byte;
          if (!ring_written[ring_head]) ring_written_count++;
          ring_written[ring_head] = 1'b1;
          ring_head = nxt;
          r.accepted = 1'b1;
        end
        // a dropped last byte still makes the start check
        check = it.last_of_message;
      end
      ctrb_pkg::MODE_DONE: begin
        ring_tail = (ring_tail + ring_inflight) % DEPTH;
        ring_inflight = 0;
        ring_busy = 1'b0;
        check = 1'b1;
      end
      ctrb_pkg::MODE_READ: begin
        if (int'(it.read_index) < DEPTH) r.read_data = ring_bytes[it.read_index];
      end
      default: ;
    endcase
    if (check && !ring_busy && ring_head != ring_tail) begin
      // a wrapped chunk stops at the end of the array
      len = (ring_head > ring_tail) ? ring_head - ring_tail : DEPTH - ring_tail;
      r.start_valid = 1'b1;
      r.start_index = FIELD_W'(ring_tail);
      r.start_length = FIELD_W'(len);
      ring_busy = 1'b1;
      ring_inflight = len;
    end
    r.space_left = FIELD_W'(ring_free());
    r.busy_res = ring_busy;
    return r;
  endfunction

  function automatic ctrb_pkg::item_t make_item(input ctrb_pkg::mode_t m,
                                                input logic [BYTE_W-1:0] d,
                                                input logic l,
                                                input logic [FIELD_W-1:0] idx);
    ctrb_pkg::item_t it;
    it.mode = m;
    it.data_byte = d;
    it.last_of_message = l;
    it.read_index = idx;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic send_request(input ctrb_pkg::item_t it, input int gap);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_ring_result(it));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_ring_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // completions until nothing is in flight or pending
  task automatic flush_ring();
    while (ring_busy || ring_head != ring_tail)
      send_request(make_item(ctrb_pkg::MODE_DONE, BYTE_W'($urandom), 1'($urandom),
                             FIELD_W'($urandom)), pick_gap());
  endtask

  always @(posedge clk) begin
    if (done) begin
      if (pending_results.size() == 0) begin
        note_failure("result strobe with no request outstanding");
      end else begin
        expected_now = pending_results.pop_front();
        if (result.accepted !== expected_now.accepted ||
            result.start_valid !== expected_now.start_valid ||
            result.start_index !== expected_now.start_index ||
            result.start_length !== expected_now.start_length ||
            result.read_data !== expected_now.read_data ||
            result.space_left !== expected_now.space_left ||
            result.busy_res !== expected_now.busy_res)
          note_failure($sformatf(
            {"mismatch exp acc=%0d sv=%0d idx=%0d len=%0d rd=%0h free=%0d busy=%0d",
             " got acc=%0d sv=%0d idx=%0d len=%0d rd=%0h free=%0d busy=%0d"},
            expected_now.accepted, expected_now.start_valid, expected_now.start_index,
            expected_now.start_length, expected_now.read_data, expected_now.space_left,
            expected_now.busy_res, result.accepted, result.start_valid,
            result.start_index, result.start_length, result.read_data,
            result.space_left, result.busy_res));
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_directed();
    send_request(make_item(ctrb_pkg::mode_t'(MODE_UNUSED), 8'hFF, 1'b1, 10'h3FF),
                 pick_gap());
    // completion with nothing in flight and nothing pending
    send_request(make_item(ctrb_pkg::MODE_DONE, 8'h00, 1'b1, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, 8'h00, 1'b0, 10'h3FF), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, 8'hFF, 1'b1, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, 8'hA5, 1'b1, 10'h000), pick_gap());
    // last mark means nothing on a read
    send_request(make_item(ctrb_pkg::MODE_READ, 8'hFF, 1'b1, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_READ, 8'h00, 1'b0, 10'h001), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_DONE, 8'h00, 1'b0, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_DONE, 8'h00, 1'b0, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_DONE, 8'h00, 1'b0, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, 8'h5A, 1'b1, 10'h3FF), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_READ, 8'h00, 1'b0, 10'h002), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, 8'h3C, 1'b0, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::mode_t'(MODE_UNUSED), 8'h00, 1'b0, 10'h000),
                 pick_gap());
    send_request(make_item(ctrb_pkg::MODE_DONE, 8'h00, 1'b1, 10'h000), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_READ, 8'h00, 1'b0, 10'h003), pick_gap());
  endtask

  task automatic test_full_ring();
    flush_ring();
    while (ring_free() != 0)
      send_request(make_item(ctrb_pkg::MODE_PUSH, BYTE_W'($urandom), 1'b0,
                             FIELD_W'($urandom)), pick_gap());
    // full ring: all three pushes are dropped, only the two marked ones check for a start
    send_request(make_item(ctrb_pkg::MODE_PUSH, BYTE_W'($urandom), 1'b0,
                           FIELD_W'($urandom)), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, BYTE_W'($urandom), 1'b1,
                           FIELD_W'($urandom)), pick_gap());
    send_request(make_item(ctrb_pkg::MODE_PUSH, BYTE_W'($urandom), 1'b1,
                           FIELD_W'($urandom)), pick_gap());
    if (ring_written[0])
      send_request(make_item(ctrb_pkg::MODE_READ, BYTE_W'($urandom), 1'($urandom),
                             10'h000), pick_gap());
    if (ring_written[DEPTH-1])
      send_request(make_item(ctrb_pkg::MODE_READ, BYTE_W'($urandom), 1'($urandom),
                             10'h3FF), pick_gap());
    flush_ring();
    wait_ring_drained();
  endtask

  task automatic test_random(input int count, input int push_w, input int done_w,
                             input bit no_gaps);
    ctrb_pkg::item_t it;
    int r;
    int idx;
    repeat (count) begin
      r = $urandom_range(99);
      it = make_item(ctrb_pkg::MODE_PUSH, BYTE_W'($urandom), ($urandom_range(5) == 0),
                     FIELD_W'($urandom));
      if (r < 2) begin
        it.mode = ctrb_pkg::mode_t'(MODE_UNUSED);
      end else if (r >= 2 + push_w && r < 2 + push_w + done_w) begin
        // completions mostly arrive while a chunk is in flight
        if (ring_busy || $urandom_range(4) == 0) it.mode = ctrb_pkg::MODE_DONE;
      end else if (r >= 2 + push_w + done_w && ring_written_count != 0) begin
        idx = $urandom_range(DEPTH - 1);
        while (!ring_written[idx]) idx = (idx + 1) % DEPTH;
        it.mode = ctrb_pkg::MODE_READ;
        it.read_index = FIELD_W'(idx);
      end
      send_request(it, no_gaps ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_ring();
    test_random(250, 60, 20, 1'b0);
    test_random(250, 55, 20, 1'b1);
    // hold off until every result is back
    wait_ring_drained();
    test_random(300, 80, 4, 1'b0);
    test_random(200, 45, 35, 1'b0);
    wait_ring_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
